/* hdl/qrs_pkg.sv */
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 48;
  localparam int ST_W       = 2;

  localparam int PROD_W = 2 * COEF_WIDTH;
  // discriminant width, capped at 64 bits for the widest coefficients
  localparam int D_W    = (2 * COEF_WIDTH + 1 > 64) ? 64 : 2 * COEF_WIDTH + 1;
  localparam int PAIRS  = (D_W + 1) / 2;
  localparam int DP_W   = 2 * PAIRS;
  localparam int SQ_N   = PAIRS + FRAC_BITS;
  localparam int Q_W    = SQ_N;
  localparam int R_W    = Q_W + 2;
  localparam int BASE_W = COEF_WIDTH + FRAC_BITS + 1;
  localparam int NUM_W  = ((BASE_W > Q_W + 1) ? BASE_W : Q_W + 1) + 1;
  localparam int DV_W   = COEF_WIDTH + 1;

  localparam logic [ST_W-1:0] ST_REAL  = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
  localparam logic [ST_W-1:0] ST_DEGEN = 2'd2;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    coef_t           a;
    coef_t           b;
  } meta_t;

endpackage

/* hdl/qrs_in_if.sv */
interface qrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrs_pkg::IN_W-1:0]      coef_a;
  logic signed [qrs_pkg::IN_W-1:0]      coef_b;
  logic signed [qrs_pkg::IN_W-1:0]      coef_c;

  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

/* hdl/qrs_out_if.sv */
interface qrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrs_pkg::OUT_W-1:0]     root_plus;
  logic signed [qrs_pkg::OUT_W-1:0]     root_minus;
  logic [qrs_pkg::ST_W-1:0]             status;

  modport source(output valid, root_plus, root_minus, status, input ready);
  modport sink(input valid, root_plus, root_minus, status, output ready);
endinterface

/* hdl/qrs_front.sv */
module qrs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [qrs_pkg::IN_W-1:0]        in_a,
  input  logic [qrs_pkg::IN_W-1:0]        in_b,
  input  logic [qrs_pkg::IN_W-1:0]        in_c,
  output logic                            out_valid,
  output logic [qrs_pkg::D_W-1:0]         out_d,
  output qrs_pkg::meta_t                  out_meta
);

  localparam int CW = qrs_pkg::COEF_WIDTH;

  logic [CW+qrs_pkg::IN_W-1:0] ext_a, ext_b, ext_c;
  qrs_pkg::coef_t a_in, b_in, c_in;
  logic [CW-1:0] am, bm, cm;

  // stage 1 registers
  logic                         v1;
  logic [qrs_pkg::PROD_W-1:0]   bb;
  logic [qrs_pkg::PROD_W-1:0]   ac;
  logic                         ac_neg;
  logic                         a_zero;
  qrs_pkg::coef_t               a1, b1;

  logic [qrs_pkg::D_W-1:0] ac4, bbe, d_next;
  logic [qrs_pkg::ST_W-1:0] st_next;

  // low bits of each field, zero extended when the coefficient is wider
  assign ext_a = {{CW{1'b0}}, in_a};
  assign ext_b = {{CW{1'b0}}, in_b};
  assign ext_c = {{CW{1'b0}}, in_c};
  assign a_in  = ext_a[CW-1:0];
  assign b_in  = ext_b[CW-1:0];
  assign c_in  = ext_c[CW-1:0];

  assign am = a_in[CW-1] ? CW'(-a_in) : CW'(a_in);
  assign bm = b_in[CW-1] ? CW'(-b_in) : CW'(b_in);
  assign cm = c_in[CW-1] ? CW'(-c_in) : CW'(c_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb     <= qrs_pkg::PROD_W'(bm) * qrs_pkg::PROD_W'(bm);
      ac     <= qrs_pkg::PROD_W'(am) * qrs_pkg::PROD_W'(cm);
      ac_neg <= a_in[CW-1] ^ c_in[CW-1];
      a_zero <= (a_in == '0);
      a1     <= a_in;
      b1     <= b_in;
    end
  end

  assign ac4 = qrs_pkg::D_W'({ac, 2'b00});
  assign bbe = qrs_pkg::D_W'(bb);

  always_comb begin
    d_next  = '0;
    st_next = qrs_pkg::ST_REAL;
    if (a_zero) begin
      st_next = qrs_pkg::ST_DEGEN;
    end else if (ac_neg || ac4 == '0) begin
      d_next = bbe + ac4;
    end else if (bbe >= ac4) begin
      d_next = bbe - ac4;
    end else begin
      st_next = qrs_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d           <= d_next;
      out_meta.status <= st_next;
      out_meta.a      <= a1;
      out_meta.b      <= b1;
    end
  end

endmodule

/* hdl/qrs_sqrt.sv */
module qrs_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [qrs_pkg::D_W-1:0]         in_d,
  input  qrs_pkg::meta_t                  in_meta,
  output logic                            out_valid,
  output logic [qrs_pkg::Q_W-1:0]         out_s,
  output qrs_pkg::meta_t                  out_meta
);

  localparam int N = qrs_pkg::SQ_N;

  logic                          v  [N+1];
  logic [qrs_pkg::DP_W-1:0]      d  [N+1];
  logic [qrs_pkg::R_W-1:0]       rm [N+1];
  logic [qrs_pkg::Q_W-1:0]       q  [N+1];
  qrs_pkg::meta_t                m  [N+1];

  assign v[0]  = in_valid;
  assign d[0]  = qrs_pkg::DP_W'(in_d);
  assign rm[0] = '0;
  assign q[0]  = '0;
  assign m[0]  = in_meta;

  // one result bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int I = N - 1 - k;
    logic [1:0]              pair;
    logic [qrs_pkg::R_W-1:0] rs, trial;
    logic                    ge;

    if (I >= qrs_pkg::FRAC_BITS) begin : g_pair
      assign pair = d[k][2*(I-qrs_pkg::FRAC_BITS) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rs    = {rm[k][qrs_pkg::R_W-3:0], pair};
    assign trial = {q[k], 2'b01};
    assign ge    = (rs >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d[k+1]  <= d[k];
        rm[k+1] <= ge ? rs - trial : rs;
        q[k+1]  <= {q[k][qrs_pkg::Q_W-2:0], ge};
        m[k+1]  <= m[k];
      end
    end
  end

  assign out_valid = v[N];
  assign out_s     = q[N];
  assign out_meta  = m[N];

endmodule

/* hdl/qrs_div.sv */
module qrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [qrs_pkg::Q_W-1:0]           in_s,
  input  qrs_pkg::meta_t                    in_meta,
  output logic                              out_valid,
  output logic signed [qrs_pkg::OUT_W-1:0]  out_plus,
  output logic signed [qrs_pkg::OUT_W-1:0]  out_minus,
  output logic [qrs_pkg::ST_W-1:0]          out_status
);

  localparam int NW = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DV_W;
  localparam int CW = qrs_pkg::COEF_WIDTH;

  logic signed [NW-1:0] base, sx;
  logic signed [NW-1:0] num_in [2];
  logic [CW-1:0]        am;

  logic                       v   [NW+1];
  logic [DW-1:0]              dv  [NW+1];
  logic [qrs_pkg::ST_W-1:0]   st  [NW+1];
  logic [NW-1:0]              n   [2][NW+1];
  logic [DW:0]                r   [2][NW+1];
  logic [NW-1:0]              qt  [2][NW+1];
  logic                       ng  [2][NW+1];

  logic signed [NW:0] res [2];

  assign base      = NW'(-(NW'(in_meta.b))) <<< qrs_pkg::FRAC_BITS;
  assign sx        = NW'({1'b0, in_s});
  assign num_in[0] = base + sx;
  assign num_in[1] = base - sx;
  assign am        = in_meta.a[CW-1] ? CW'(-in_meta.a) : CW'(in_meta.a);

  // input stage: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= {am, 1'b0};
      st[0] <= in_meta.status;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        n[l][0]  <= num_in[l][NW-1] ? NW'(-num_in[l]) : NW'(num_in[l]);
        r[l][0]  <= '0;
        qt[l][0] <= '0;
        ng[l][0] <= num_in[l][NW-1] ^ in_meta.a[CW-1];
      end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < NW; j++) begin : g_bit
      logic [DW:0] rs;
      logic        ge;

      assign rs = {r[l][j][DW-1:0], n[l][j][NW-1]};
      assign ge = (rs >= {1'b0, dv[j]});

      always_ff @(posedge clk) begin
        if (en) begin
          n[l][j+1]  <= {n[l][j][NW-2:0], 1'b0};
          r[l][j+1]  <= ge ? rs - {1'b0, dv[j]} : rs;
          qt[l][j+1] <= {qt[l][j][NW-2:0], ge};
          ng[l][j+1] <= ng[l][j];
        end
      end
    end

    assign res[l] = ng[l][NW] ? -($signed({1'b0, qt[l][NW]}))
                              : $signed({1'b0, qt[l][NW]});
  end

  for (genvar j = 0; j < NW; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dv[j];
        st[j+1] <= st[j];
      end
    end
  end

  // output stage: sign, and zero roots unless both are real
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= st[NW];
      if (st[NW] == qrs_pkg::ST_REAL) begin
        out_plus  <= qrs_pkg::OUT_W'(res[0]);
        out_minus <= qrs_pkg::OUT_W'(res[1]);
      end else begin
        out_plus  <= '0;
        out_minus <= '0;
      end
    end
  end

endmodule

/* hdl/quadratic_real_root_solver.sv */
// channel  dir  payload                          transfer
// coef     in   coef_a, coef_b, coef_c (s16)     valid && ready
// root     out  root_plus, root_minus (s48), st  valid && ready
//
// one item enters per cycle while the skid register is empty; the pipeline runs through
// the front end, the bit-per-stage square root and divider, and the output register
// rst is synchronous and clears only the valid bits
// a waiting result sits in the output register, a second one in the skid
// register; the pipeline stalls as a whole only while the skid register is full
module quadratic_real_root_solver (
  input  logic      clk,
  input  logic      rst,
  qrs_in_if.sink    coef,
  qrs_out_if.source root
);

  logic en;

  logic                     f_valid;
  logic [qrs_pkg::D_W-1:0]  f_d;
  qrs_pkg::meta_t           f_meta;

  logic                     s_valid;
  logic [qrs_pkg::Q_W-1:0]  s_s;
  qrs_pkg::meta_t           s_meta;

  logic                              p_valid;
  logic signed [qrs_pkg::OUT_W-1:0]  p_plus, p_minus;
  logic [qrs_pkg::ST_W-1:0]          p_status;

  logic                              out_v;
  logic signed [qrs_pkg::OUT_W-1:0]  out_plus, out_minus;
  logic [qrs_pkg::ST_W-1:0]          out_status;

  logic                              skid_v;
  logic signed [qrs_pkg::OUT_W-1:0]  skid_plus, skid_minus;
  logic [qrs_pkg::ST_W-1:0]          skid_status;

  assign en         = !skid_v;
  assign coef.ready = en;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coef.valid),
    .in_a      (coef.coef_a),
    .in_b      (coef.coef_b),
    .in_c      (coef.coef_c),
    .out_valid (f_valid),
    .out_d     (f_d),
    .out_meta  (f_meta)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_d      (f_d),
    .in_meta   (f_meta),
    .out_valid (s_valid),
    .out_s     (s_s),
    .out_meta  (s_meta)
  );

  qrs_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_valid),
    .in_s       (s_s),
    .in_meta    (s_meta),
    .out_valid  (p_valid),
    .out_plus   (p_plus),
    .out_minus  (p_minus),
    .out_status (p_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (root.ready) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (!out_v || root.ready) begin
      out_v <= p_valid;
    end else if (p_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (root.ready) begin
        out_plus   <= skid_plus;
        out_minus  <= skid_minus;
        out_status <= skid_status;
      end
    end else if (!out_v || root.ready) begin
      out_plus   <= p_plus;
      out_minus  <= p_minus;
      out_status <= p_status;
    end else begin
      skid_plus   <= p_plus;
      skid_minus  <= p_minus;
      skid_status <= p_status;
    end
  end

  assign root.valid      = out_v;
  assign root.root_plus  = out_plus;
  assign root.root_minus = out_minus;
  assign root.status     = out_status;

endmodule
